FILE: rtl/fplw_pkg.sv
// Shared types and codes for the four-level page table walker.
package fplw_pkg;

	// Input beat commands
	localparam logic CMD_TRANSLATE = 1'b0;
	localparam logic CMD_RESPONSE  = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_REQUEST = 2'd0;
	localparam logic [1:0] KIND_DONE    = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// Error codes
	localparam logic ERR_ROOT_INVALID = 1'b0;
	localparam logic ERR_NOT_PRESENT  = 1'b1;

	// Configuration register indexes
	localparam logic CFG_ROOT_TABLE  = 1'b0;
	localparam logic CFG_READ_OFFSET = 1'b1;

	localparam int VA_BITS = 48;

	typedef struct packed {
		logic        cmd;
		logic [63:0] virt_addr;
		logic [63:0] entry_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [63:0] address;
		logic [63:0] page_limit;
		logic [1:0]  map_level;
		logic        error_code;
	} out_item_t;

	// Walk state carried between beats
	typedef struct packed {
		logic               busy;
		logic [1:0]         level;
		logic [VA_BITS-1:0] va;
	} walk_state_t;

endpackage

FILE: rtl/fplw_walk_step.sv
// Combinational step of the walk: one beat and the current state give the result and next state.
module fplw_walk_step
	import fplw_pkg::*;
(
	input  in_item_t    item,
	input  walk_state_t state,
	input  logic [63:0] root_table_address,
	input  logic [63:0] read_address_offset,
	output logic        result_valid,
	output out_item_t   result,
	output walk_state_t next_state
);

	// Nine index bits of the virtual address for one level
	function automatic logic [8:0] level_index(input logic [VA_BITS-1:0] va, input logic [1:0] lvl);
		logic [8:0] idx;
		case (lvl)
			2'd0:    idx = va[47:39];
			2'd1:    idx = va[38:30];
			2'd2:    idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

	// Page size in bytes for a leaf at the given level
	function automatic logic [63:0] page_size(input logic [1:0] lvl);
		logic [63:0] size;
		case (lvl)
			2'd0:    size = 64'd1 << 39;
			2'd1:    size = 64'd1 << 30;
			2'd2:    size = 64'd1 << 21;
			default: size = 64'd1 << 12;
		endcase
		return size;
	endfunction

	logic               is_translate;
	logic [63:0]        entry_paddr;
	logic               present;
	logic               leaf;
	logic [1:0]         child_level;
	logic [VA_BITS-1:0] idx_va;
	logic [1:0]         req_level;
	logic [63:0]        req_table;
	logic [63:0]        req_address;
	logic [63:0]        leaf_size;

	assign is_translate = (item.cmd == CMD_TRANSLATE);
	assign entry_paddr  = {12'd0, item.entry_data[51:12], 12'd0};
	assign present      = item.entry_data[0];
	assign leaf         = (state.level == 2'd3) || item.entry_data[7];
	assign child_level  = state.level + 2'd1;
	assign leaf_size    = page_size(state.level);

	// One shared adder forms the entry read address for either kind of request
	assign idx_va      = is_translate ? item.virt_addr[VA_BITS-1:0] : state.va;
	assign req_level   = is_translate ? 2'd0 : child_level;
	assign req_table   = is_translate ? root_table_address : entry_paddr;
	assign req_address = req_table + read_address_offset
		+ {52'd0, level_index(idx_va, req_level), 3'b000};

	// Result and state update
	always_comb begin
		result_valid = 1'b0;
		result       = '0;
		next_state   = state;
		if (is_translate) begin
			result_valid     = 1'b1;
			next_state.va    = item.virt_addr[VA_BITS-1:0];
			next_state.level = 2'd0;
			if (root_table_address[63]) begin
				next_state.busy    = 1'b0;
				result.result_kind = KIND_ERROR;
				result.error_code  = ERR_ROOT_INVALID;
			end else begin
				next_state.busy    = 1'b1;
				result.result_kind = KIND_REQUEST;
				result.address     = req_address;
			end
		end else if (state.busy) begin
			result_valid = 1'b1;
			if (!present) begin
				next_state.busy    = 1'b0;
				result.result_kind = KIND_ERROR;
				result.map_level   = state.level;
				result.error_code  = ERR_NOT_PRESENT;
			end else if (leaf) begin
				next_state.busy    = 1'b0;
				result.result_kind = KIND_DONE;
				result.address     = entry_paddr
					| ({16'd0, state.va} & (leaf_size - 64'd1));
				result.page_limit  = entry_paddr + leaf_size;
				result.map_level   = state.level;
			end else begin
				next_state.level   = child_level;
				result.result_kind = KIND_REQUEST;
				result.address     = req_address;
				result.map_level   = child_level;
			end
		end
	end

endmodule

FILE: rtl/four_level_page_walker.sv
// Top level of the four-level page table walker: input register, walk state and result register.
//
//  Channel | Direction | Handshake               | Payload
//  in      | in        | in_valid / in_stall     | in_data  (cmd, virt_addr, entry_data)
//  out     | out       | out_valid / out_stall   | out_data (kind, address, end, level, error)
//  cfg     | in        | cfg_write               | cfg_index, cfg_data
//
// Each beat is held in the input register and is then resolved combinationally into
// the result register; one beat is taken per cycle while the output does not stall.
// The walk state updates as the beat leaves the input register.
// Reset empties both registers and leaves the walker idle with both configuration
// registers at zero.
// A stall on the output holds the result register and, once the input register is
// also full, raises in_stall.
module four_level_page_walker
	import fplw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	logic        valid_s1;
	in_item_t    item_s1;
	walk_state_t state_q;
	walk_state_t state_next;
	logic [63:0] root_table_q;
	logic [63:0] read_offset_q;
	logic        out_valid_q;
	out_item_t   out_data_q;
	logic        step_valid;
	out_item_t   step_result;
	logic        out_free;
	logic        advance;
	logic        in_accept;

	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_table_q  <= '0;
			read_offset_q <= '0;
		end else if (cfg_write) begin
			if (cfg_index == CFG_ROOT_TABLE) begin
				root_table_q <= cfg_data;
			end else begin
				read_offset_q <= cfg_data;
			end
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_data;
		end
	end

	fplw_walk_step u_step (
		.item                (item_s1),
		.state               (state_q),
		.root_table_address  (root_table_q),
		.read_address_offset (read_offset_q),
		.result_valid        (step_valid),
		.result              (step_result),
		.next_state          (state_next)
	);

	// Walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_valid) begin
			out_data_q <= step_result;
		end
	end

	// A response that arrives while idle must not produce a result
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.cmd == CMD_RESPONSE && !state_q.busy) |=> !out_valid)
		else $error("result produced for a response while idle");

	// Any error or finished walk leaves the walker idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_valid && (step_result.result_kind == KIND_ERROR
			|| step_result.result_kind == KIND_DONE)) |=> !state_q.busy)
		else $error("walker still busy after error or completion");

	// A translate beat always yields a result and restarts at the top level
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.cmd == CMD_TRANSLATE) |=> (out_valid && state_q.level == 2'd0))
		else $error("translate beat did not restart the walk");

	// Walk state only moves when a beat leaves the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("walk state changed without a beat");

endmodule

FILE: tb/walk_checker.sv
// Checker for the page walker: follows all channels, predicts each walk step and compares results.
`timescale 1ns / 100ps

module walk_checker
	import fplw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_item_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_item_t   out_data,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	output int          failures,
	output int          pending,
	output int          checked
);

	// Shadow copy of the registers and the walk state
	logic [63:0]        root_addr;
	logic [63:0]        read_offset;
	logic               walking;
	logic [1:0]         walk_lvl;
	logic [VA_BITS-1:0] walk_va;

	out_item_t awaited_results[$];

	// Address of the entry for level l inside the table at tbl_base.
	function automatic logic [63:0] entry_read_addr(logic [63:0] tbl_base, logic [1:0] l);
		logic [8:0] idx;
		idx = walk_va[(39 - 9 * int'(l)) +: 9];
		return tbl_base + read_offset + {52'd0, idx, 3'b000};
	endfunction

	// Advance the walk by one accepted input beat and queue any result it causes.
	task automatic predict_walk_step(input in_item_t b);
		out_item_t   r;
		logic [63:0] paddr;
		logic [63:0] size;
		logic [1:0]  next_lvl;
		r = '0;
		if (b.cmd == CMD_TRANSLATE) begin
			walk_va  = b.virt_addr[VA_BITS-1:0];
			walk_lvl = 2'd0;
			if (root_addr[63]) begin
				// An invalid root fails at once and leaves the walker idle.
				walking       = 1'b0;
				r.result_kind = KIND_ERROR;
				r.error_code  = ERR_ROOT_INVALID;
			end else begin
				walking       = 1'b1;
				r.result_kind = KIND_REQUEST;
				r.address     = entry_read_addr(root_addr, 2'd0);
			end
			awaited_results.push_back(r);
		end else if (walking) begin
			paddr = b.entry_data & 64'h000f_ffff_ffff_f000;
			size  = 64'd1 << (39 - 9 * int'(walk_lvl));
			r.map_level = walk_lvl;
			if (!b.entry_data[0]) begin
				walking       = 1'b0;
				r.result_kind = KIND_ERROR;
				r.error_code  = ERR_NOT_PRESENT;
			end else if (walk_lvl == 2'd3 || b.entry_data[7]) begin
				// Leaf: the page offset comes from the virtual address.
				walking       = 1'b0;
				r.result_kind = KIND_DONE;
				r.address     = paddr | ({16'd0, walk_va} & (size - 64'd1));
				r.page_limit  = paddr + size;
			end else begin
				next_lvl      = walk_lvl + 2'd1;
				walk_lvl      = next_lvl;
				r.result_kind = KIND_REQUEST;
				r.address     = entry_read_addr(paddr, next_lvl);
				r.map_level   = next_lvl;
			end
			awaited_results.push_back(r);
		end
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		if (failures < 40) begin
			$display("%0t: result %0d field %s is %h, expected %h", $time, checked, field,
				got, want);
		end
		failures++;
	endtask

	// Compare one accepted result beat with the oldest prediction.
	task automatic check_result(input out_item_t got);
		out_item_t want;
		checked++;
		if (awaited_results.size() == 0) begin
			report_mismatch("unexpected beat", got.address, '0);
		end else begin
			want = awaited_results.pop_front();
			if (got.result_kind !== want.result_kind)
				report_mismatch("result_kind", got.result_kind, want.result_kind);
			if (got.address !== want.address)
				report_mismatch("address", got.address, want.address);
			if (got.page_limit !== want.page_limit)
				report_mismatch("page_limit", got.page_limit, want.page_limit);
			if (got.map_level !== want.map_level)
				report_mismatch("map_level", got.map_level, want.map_level);
			if (got.error_code !== want.error_code)
				report_mismatch("error_code", got.error_code, want.error_code);
		end
	endtask

	// Watch the channels at each clock edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_addr   = '0;
			read_offset = '0;
			walking     = 1'b0;
			walk_lvl    = '0;
			walk_va     = '0;
			failures    = 0;
			checked     = 0;
			awaited_results.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_result(out_data);
			if (in_valid && !in_stall)
				predict_walk_step(in_data);
			if (cfg_write) begin
				case (cfg_index)
					CFG_ROOT_TABLE:  root_addr = cfg_data;
					CFG_READ_OFFSET: read_offset = cfg_data;
				endcase
			end
			pending <= awaited_results.size();
		end
	end

endmodule

FILE: tb/four_level_page_walker_test.sv
// Testbench top for the page walker: clock, reset, register writes, beat traffic and verdict.
`timescale 1ns / 100ps

module four_level_page_walker_test;
	import fplw_pkg::*;

	localparam int TARGET_BEATS = 1400;
	localparam int PHASE_BEATS  = 200;
	localparam int QUIET_LIMIT  = 2000;
	localparam int LONG_HOLD    = 200;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_write;
	logic        cfg_index;
	logic [63:0] cfg_data;

	int failures;
	int pending;
	int checked;

	int          beats_sent;
	int          burst_left;
	int          settings_used;
	int          quiet_cycles;
	logic [63:0] cur_root;
	bit          random_phase;

	four_level_page_walker DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	walk_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.failures  (failures),
		.pending   (pending),
		.checked   (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// End the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout after %0d quiet cycles", quiet_cycles);
			$display("four_level_page_walker_test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: random stalls, and one long hold-off once random traffic starts.
	initial begin : result_sink
		int  r;
		bit  held_long;
		held_long = 1'b0;
		out_stall = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (random_phase && !held_long) begin
				held_long = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (r < 55) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else if (r < 62) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end else if (r < 95) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Random table entry with the present and page size bits forced.
	function automatic logic [63:0] rand_entry(bit present, bit ps);
		logic [63:0] e;
		e    = rand64();
		e[0] = present;
		e[7] = ps;
		return e;
	endfunction

	// Offer one beat, hold it until taken, then maybe leave a gap.
	task automatic send_beat(input in_item_t b);
		int r;
		in_data  <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		beats_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				burst_left = $urandom_range(20, 60);
			end else if (r >= 50) begin
				in_valid <= 1'b0;
				if (r < 92)
					repeat ($urandom_range(1, 3)) @(posedge clk);
				else
					repeat ($urandom_range(6, 40)) @(posedge clk);
			end
		end
	endtask

	task automatic translate(input logic [63:0] va);
		send_beat('{cmd: CMD_TRANSLATE, virt_addr: va, entry_data: rand64()});
	endtask

	task automatic respond(input logic [63:0] entry);
		send_beat('{cmd: CMD_RESPONSE, virt_addr: rand64(), entry_data: entry});
	endtask

	// Drain the walker, then write both registers.
	task automatic set_config(input logic [63:0] root, input logic [63:0] offset);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// A response to an idle walker leaves no result, so allow it to clear too.
		repeat (4) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_ROOT_TABLE;
		cfg_data  <= root;
		@(posedge clk);
		cfg_index <= CFG_READ_OFFSET;
		cfg_data  <= offset;
		@(posedge clk);
		cfg_write <= 1'b0;
		cur_root = root;
		settings_used++;
	endtask

	// One well-formed walk with random entries, sometimes cut short.
	task automatic run_walk();
		bit present;
		bit ps;
		translate(rand64());
		for (int l = 0; l < 4; l++) begin
			if ($urandom_range(0, 19) == 0)
				break;
			present = ($urandom_range(0, 9) != 0);
			ps      = (l < 3) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 1) == 1);
			respond(rand_entry(present, ps));
			if (!present || ps || l == 3)
				break;
		end
	endtask

	initial begin : stimulus
		int          r;
		int          phase_start;
		logic [63:0] offset;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_write     = 1'b0;
		cfg_index     = CFG_ROOT_TABLE;
		cfg_data      = '0;
		beats_sent    = 0;
		burst_left    = 0;
		settings_used = 0;
		cur_root      = '0;
		random_phase  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a full four-level walk ending on a 4 KB page.
		set_config(64'h0000_0000_0010_0000, 64'h0);
		translate(64'h0);
		respond(64'h0000_0000_0020_0001);
		respond(64'h0000_0000_0030_0001);
		respond(64'h0000_0000_0040_0001);
		respond(64'h0000_0000_0050_0001);
		// Leaf at the top level, with every entry bit set.
		translate(64'hffff_ffff_ffff_ffff);
		respond(64'hffff_ffff_ffff_ffff);
		// 1 GB and 2 MB leaves; entry bits above 51 and bit 11 must be dropped.
		translate(64'h0000_7fc0_3fe0_1ff8);
		respond(64'h0000_0000_0000_0001);
		respond(64'h000f_ffff_c000_0081);
		translate(64'h0000_5555_aaaa_5555);
		respond(64'hfff0_0000_0000_0f01);
		respond(64'h0000_0000_0000_0001);
		respond(64'h8000_0000_0060_0881);
		// Entries not present at the top and at a middle level.
		translate(64'hffff_0000_0000_0000);
		respond(64'h0);
		translate(64'h0000_8000_0000_0fff);
		respond(64'h0000_0000_0000_0001);
		respond(64'hffff_ffff_ffff_fffe);
		// Response with no walk running is ignored.
		respond(64'h0000_0000_0000_0081);
		// A new translation abandons the running walk.
		translate(64'h0000_1234_5678_9abc);
		respond(64'h0000_0000_0000_1001);
		translate(64'h0000_0fed_cba9_8765);
		respond(64'h0000_0000_0000_0001);

		// Invalid roots: each translation fails and the response after the first is ignored.
		set_config(64'h8000_0000_0000_0000, 64'h0);
		translate(rand64());
		respond(rand_entry(1'b1, 1'b0));
		set_config(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
		translate(rand64());
		// Largest valid root with an offset that wraps the read address.
		set_config(64'h7fff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
		translate(64'h0000_ffff_ffff_ffff);
		respond(64'hffff_ffff_ffff_f001);
		respond(64'hffff_ffff_ffff_f001);
		respond(64'hffff_ffff_ffff_f001);
		respond(64'hffff_ffff_ffff_ff7f);

		// Random part: mostly whole walks, some stray responses and restarts.
		random_phase = 1'b1;
		phase_start  = beats_sent;
		while (beats_sent < TARGET_BEATS) begin
			if (beats_sent - phase_start >= PHASE_BEATS) begin
				r = $urandom_range(0, 2);
				offset = (r == 0) ? 64'h0 : (r == 1) ? 64'hffff_ffff_ffff_ffff : rand64();
				cur_root = rand64();
				cur_root[63] = ($urandom_range(0, 9) == 0);
				set_config(cur_root, offset);
				phase_start = beats_sent;
			end
			r = $urandom_range(0, 99);
			if (r < 85)
				run_walk();
			else if (r < 93)
				respond(rand_entry(($urandom_range(0, 1) == 1), ($urandom_range(0, 1) == 1)));
			else
				translate(rand64());
		end

		// Let every result come back before the verdict.
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		$display("Sent %0d beats and checked %0d results over %0d register settings,",
			beats_sent, checked, settings_used);
		$display("including invalid and extreme roots, wrapping offsets and a long output hold.");
		if (failures == 0 && pending == 0) begin
			$display("four_level_page_walker_test passed");
		end else begin
			$display("four_level_page_walker_test failed");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/fplw_pkg.sv
rtl/fplw_walk_step.sv
rtl/four_level_page_walker.sv
tb/walk_checker.sv
tb/four_level_page_walker_test.sv
